@@ design/arp_cache_with_next_hop_top_macros.svh @@
// Assertion macros for the top-level design file.
`ifndef ARP_CACHE_WITH_NEXT_HOP_TOP_MACROS_SVH
`define ARP_CACHE_WITH_NEXT_HOP_TOP_MACROS_SVH

// Implication or plain property, checked on every rising clock edge out of reset.
`define ARPC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition that must never be true on a rising clock edge out of reset.
`define ARPC_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

@@ design/arpc_pkg.sv @@
`default_nettype none

package arpc_pkg;

	localparam int IP_W          = 32;
	localparam int MAC_W         = 48;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 32;
	localparam int STATUS_W      = 2;
	localparam int ENTRIES_DEF   = 16;

	// request kinds
	localparam logic ACT_LEARN   = 1'b0;
	localparam logic ACT_RESOLVE = 1'b1;

	// result status codes
	localparam logic [STATUS_W-1:0] STATUS_UPDATED  = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_INSERTED = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd2;
	localparam logic [STATUS_W-1:0] STATUS_RESOLVE  = 2'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_HOST_IP     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SUBNET_MASK = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GATEWAY_IP  = 2'd2;

	// control that walks along the cell row with a request
	typedef struct packed {
		logic vld;        // request present at this hop
		logic act;        // ACT_LEARN or ACT_RESOLVE
		logic found;      // a valid entry matched upstream
		logic free_seen;  // a free entry was seen upstream
	} tok_ctl_t;

endpackage

`default_nettype wire

@@ design/arpc_cell.sv @@
`default_nettype none

module arpc_cell
	import arpc_pkg::*;
#(
	parameter int IDX_W    = $clog2(ENTRIES_DEF),
	parameter int CELL_IDX = 0
) (
	input  wire                    clk,
	input  wire                    arst_n,
	// request from the left neighbor
	input  tok_ctl_t               in_ctl,
	input  wire  [IP_W-1:0]        in_ip,
	input  wire  [MAC_W-1:0]       in_mac,
	input  wire  [IDX_W-1:0]       in_free_idx,
	// request to the right neighbor
	output tok_ctl_t               out_ctl,
	output logic [IP_W-1:0]        out_ip,
	output logic [MAC_W-1:0]       out_mac,
	output logic [IDX_W-1:0]       out_free_idx,
	// insert broadcast from the controller
	input  wire                    ins_en,
	input  wire  [IDX_W-1:0]       ins_idx,
	input  wire  [IP_W-1:0]        ins_ip,
	input  wire  [MAC_W-1:0]       ins_mac
);

	logic              valid_q;
	logic [IP_W-1:0]   ip_q;
	logic [MAC_W-1:0]  mac_q;

	tok_ctl_t          fwd_ctl_q;
	logic [IP_W-1:0]   fwd_ip_q;
	logic [MAC_W-1:0]  fwd_mac_q;
	logic [IDX_W-1:0]  fwd_free_idx_q;

	logic     match;
	logic     take_free;
	logic     ins_here;
	tok_ctl_t nxt_ctl;

	assign match     = in_ctl.vld && valid_q && (ip_q == in_ip);
	assign take_free = in_ctl.vld && !valid_q && !in_ctl.free_seen;
	assign ins_here  = ins_en && (ins_idx == IDX_W'(CELL_IDX));

	always_comb begin
		nxt_ctl           = in_ctl;
		nxt_ctl.found     = in_ctl.found | match;
		nxt_ctl.free_seen = in_ctl.free_seen | take_free;
	end

	// entry valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ins_here) begin
			valid_q <= 1'b1;
		end
	end

	// entry payload: insert from the controller, MAC update on a learn hit
	always_ff @(posedge clk) begin
		if (ins_here) begin
			ip_q  <= ins_ip;
			mac_q <= ins_mac;
		end else if (match && in_ctl.act == ACT_LEARN) begin
			mac_q <= in_mac;
		end
	end

	// hop control to the neighbor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_ctl_q <= '0;
		end else begin
			fwd_ctl_q <= nxt_ctl;
		end
	end

	// hop payload: a resolve hit picks up this entry's MAC
	always_ff @(posedge clk) begin
		fwd_ip_q <= in_ip;
		if (match && in_ctl.act == ACT_RESOLVE && !in_ctl.found) begin
			fwd_mac_q <= mac_q;
		end else begin
			fwd_mac_q <= in_mac;
		end
		fwd_free_idx_q <= take_free ? IDX_W'(CELL_IDX) : in_free_idx;
	end

	assign out_ctl      = fwd_ctl_q;
	assign out_ip       = fwd_ip_q;
	assign out_mac      = fwd_mac_q;
	assign out_free_idx = fwd_free_idx_q;

endmodule

`default_nettype wire

@@ design/arp_cache_with_next_hop_top.sv @@
// Channel   | Signals                                   | Handshake
// ----------+-------------------------------------------+-------------------------------
// request   | action, ip_addr, mac_addr                 | taken when start && !busy
// result    | status, hit, next_hop_ip, mac_out         | done, one cycle, no stall
// config    | cfg_idx, cfg_wdata                        | written when cfg_we
//
// The accepting edge loads the head register; the request then walks the row of
// TABLE_ENTRIES cells one cell per cycle, and the result register strobes done once it leaves the last cell.
// busy is low again in the done cycle, so a new request may be accepted while
// the result is shown; the block takes no new request while one is in the cell row.
// Reset clears all valid bits and the config registers at once; no clearing pass.
// The receiver cannot stall: each result is shown for exactly one cycle.
`default_nettype none
`include "arp_cache_with_next_hop_top_macros.svh"

module arp_cache_with_next_hop_top
	import arpc_pkg::*;
#(
	parameter int TABLE_ENTRIES = ENTRIES_DEF
) (
	input  wire                    clk,
	input  wire                    arst_n,
	// request
	input  wire                    start,
	output logic                   busy,
	input  wire                    action,
	input  wire  [IP_W-1:0]        ip_addr,
	input  wire  [MAC_W-1:0]       mac_addr,
	// result
	output logic                   done,
	output logic [STATUS_W-1:0]    status,
	output logic                   hit,
	output logic [IP_W-1:0]        next_hop_ip,
	output logic [MAC_W-1:0]       mac_out,
	// configuration
	input  wire                    cfg_we,
	input  wire  [CFG_IDX_W-1:0]   cfg_idx,
	input  wire  [CFG_DATA_W-1:0]  cfg_wdata
);

	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

	logic [IP_W-1:0] host_ip_q;
	logic [IP_W-1:0] subnet_mask_q;
	logic [IP_W-1:0] gateway_ip_q;

	logic            busy_q;
	logic            accept;
	logic            off_subnet;
	logic [IP_W-1:0] hop;

	tok_ctl_t         head_ctl_q;
	logic [IP_W-1:0]  head_ip_q;
	logic [MAC_W-1:0] head_mac_q;

	tok_ctl_t         ch_ctl      [TABLE_ENTRIES+1];
	logic [IP_W-1:0]  ch_ip       [TABLE_ENTRIES+1];
	logic [MAC_W-1:0] ch_mac      [TABLE_ENTRIES+1];
	logic [IDX_W-1:0] ch_free_idx [TABLE_ENTRIES+1];
	logic [TABLE_ENTRIES:0] ch_vld;

	tok_ctl_t        tail;
	logic            ins_en;

	logic                done_q;
	logic [STATUS_W-1:0] status_q;
	logic                hit_q;
	logic [IP_W-1:0]     next_hop_q;
	logic [MAC_W-1:0]    mac_out_q;

	assign accept = start && !busy_q;
	assign busy   = busy_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			host_ip_q     <= '0;
			subnet_mask_q <= '0;
			gateway_ip_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_HOST_IP:     host_ip_q     <= cfg_wdata;
				REG_SUBNET_MASK: subnet_mask_q <= cfg_wdata;
				REG_GATEWAY_IP:  gateway_ip_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// next hop: gateway for off-subnet destinations of a resolve request
	assign off_subnet = (ip_addr & subnet_mask_q) != (host_ip_q & subnet_mask_q);
	assign hop = (action == ACT_RESOLVE && off_subnet) ? gateway_ip_q : ip_addr;

	// head of the cell row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_ctl_q <= '0;
		end else begin
			head_ctl_q.vld       <= accept;
			head_ctl_q.act       <= action;
			head_ctl_q.found     <= 1'b0;
			head_ctl_q.free_seen <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			head_ip_q  <= hop;
			head_mac_q <= (action == ACT_LEARN) ? mac_addr : '0;
		end
	end

	assign ch_ctl[0]      = head_ctl_q;
	assign ch_ip[0]       = head_ip_q;
	assign ch_mac[0]      = head_mac_q;
	assign ch_free_idx[0] = '0;

	// row of table cells
	for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
		arpc_cell #(
			.IDX_W    (IDX_W),
			.CELL_IDX (k)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.in_ctl       (ch_ctl[k]),
			.in_ip        (ch_ip[k]),
			.in_mac       (ch_mac[k]),
			.in_free_idx  (ch_free_idx[k]),
			.out_ctl      (ch_ctl[k+1]),
			.out_ip       (ch_ip[k+1]),
			.out_mac      (ch_mac[k+1]),
			.out_free_idx (ch_free_idx[k+1]),
			.ins_en       (ins_en),
			.ins_idx      (ch_free_idx[TABLE_ENTRIES]),
			.ins_ip       (ch_ip[TABLE_ENTRIES]),
			.ins_mac      (ch_mac[TABLE_ENTRIES])
		);
	end

	for (genvar k = 0; k <= TABLE_ENTRIES; k++) begin : g_vld
		assign ch_vld[k] = ch_ctl[k].vld;
	end

	// end of the row: insert a new pair into the lowest free entry
	assign tail   = ch_ctl[TABLE_ENTRIES];
	assign ins_en = tail.vld && tail.act == ACT_LEARN && !tail.found && tail.free_seen;

	// busy from accept until the request leaves the row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (accept) begin
			busy_q <= 1'b1;
		end else if (tail.vld) begin
			busy_q <= 1'b0;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= tail.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (tail.vld) begin
			if (tail.act == ACT_RESOLVE) begin
				status_q   <= STATUS_RESOLVE;
				hit_q      <= tail.found;
				next_hop_q <= ch_ip[TABLE_ENTRIES];
				mac_out_q  <= tail.found ? ch_mac[TABLE_ENTRIES] : '0;
			end else begin
				priority if (tail.found) begin
					status_q <= STATUS_UPDATED;
				end else if (tail.free_seen) begin
					status_q <= STATUS_INSERTED;
				end else begin
					status_q <= STATUS_FULL;
				end
				hit_q      <= 1'b0;
				next_hop_q <= '0;
				mac_out_q  <= '0;
			end
		end
	end

	assign done        = done_q;
	assign status      = status_q;
	assign hit         = hit_q;
	assign next_hop_ip = next_hop_q;
	assign mac_out     = mac_out_q;

	// checks
	`ARPC_ASSERT(a_one_req, $countones(ch_vld) <= 1, "more than one request in the cell row")
	`ARPC_ASSERT(a_accept_busy, accept |=> busy, "busy not raised after accept")
	`ARPC_NEVER(a_done_busy, done && busy, "result strobed while still busy")
	`ARPC_ASSERT(a_learn_zero, done && status != STATUS_RESOLVE |-> !hit && next_hop_ip == '0, "learn result carries resolve fields")

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
`timescale 1ns / 1ps

module testbench
	import arpc_pkg::*;
();

	localparam int N_ENTRIES = ENTRIES_DEF;
	// enough addresses to fill the table exactly
	localparam int POOL_SIZE = ENTRIES_DEF;
	// index past the register list, must be ignored
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE_CYCLES = 2 * N_ENTRIES + 8;
	localparam int RAND_PHASES = 6;
	localparam int PHASE_REQUESTS = 200;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic                hit;
		logic [IP_W-1:0]     hop;
		logic [MAC_W-1:0]    mac;
	} arp_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic                  action = ACT_LEARN;
	logic [IP_W-1:0]       ip_addr = '0;
	logic [MAC_W-1:0]      mac_addr = '0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_idx = REG_HOST_IP;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	wire                   busy;
	wire                   done;
	wire  [STATUS_W-1:0]   status;
	wire                   hit;
	wire  [IP_W-1:0]       next_hop_ip;
	wire  [MAC_W-1:0]      mac_out;

	// shadow of the block's registers and table
	logic [IP_W-1:0]  cur_host = '0;
	logic [IP_W-1:0]  cur_mask = '0;
	logic [IP_W-1:0]  cur_gateway = '0;
	bit               tbl_valid [N_ENTRIES];
	logic [IP_W-1:0]  tbl_ip [N_ENTRIES];
	logic [MAC_W-1:0] tbl_mac [N_ENTRIES];

	logic [IP_W-1:0]  ip_pool [POOL_SIZE];
	arp_result_t      awaited_outcomes [$];
	int               mismatches = 0;
	int               cycles = 0;
	bit               pace_on = 1'b1;

	arp_cache_with_next_hop_top uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.action      (action),
		.ip_addr     (ip_addr),
		.mac_addr    (mac_addr),
		.done        (done),
		.status      (status),
		.hit         (hit),
		.next_hop_ip (next_hop_ip),
		.mac_out     (mac_out),
		.cfg_we      (cfg_we),
		.cfg_idx     (cfg_idx),
		.cfg_wdata   (cfg_wdata)
	);

	always #10 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// lowest valid entry holding ip, -1 if none
	function automatic int find_slot(logic [IP_W-1:0] ip);
		for (int i = 0; i < N_ENTRIES; i++) begin
			if (tbl_valid[i] && tbl_ip[i] == ip)
				return i;
		end
		return -1;
	endfunction

	// answer of the cache to one request; updates the shadow table
	function automatic arp_result_t cache_outcome(logic act, logic [IP_W-1:0] ip,
			logic [MAC_W-1:0] mac);
		arp_result_t r;
		int slot;
		int free_slot;
		logic [IP_W-1:0] hop;
		r = '0;
		if (act == ACT_LEARN) begin
			slot = find_slot(ip);
			free_slot = -1;
			for (int i = 0; i < N_ENTRIES; i++) begin
				if (!tbl_valid[i] && free_slot < 0)
					free_slot = i;
			end
			if (slot >= 0) begin
				tbl_mac[slot] = mac;
				r.status = STATUS_UPDATED;
			end else if (free_slot >= 0) begin
				tbl_valid[free_slot] = 1'b1;
				tbl_ip[free_slot] = ip;
				tbl_mac[free_slot] = mac;
				r.status = STATUS_INSERTED;
			end else begin
				r.status = STATUS_FULL;
			end
		end else begin
			// off-subnet destinations go through the gateway
			hop = ((ip & cur_mask) != (cur_host & cur_mask)) ? cur_gateway : ip;
			slot = find_slot(hop);
			r.status = STATUS_RESOLVE;
			r.hop = hop;
			if (slot >= 0) begin
				r.hit = 1'b1;
				r.mac = tbl_mac[slot];
			end
		end
		return r;
	endfunction

	function automatic bit in_pool(logic [IP_W-1:0] ip, int count);
		for (int i = 0; i < count; i++) begin
			if (ip_pool[i] == ip)
				return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic logic [IP_W-1:0] rand_ip_outside_pool();
		logic [IP_W-1:0] ip;
		do
			ip = $urandom;
		while (in_pool(ip, POOL_SIZE));
		return ip;
	endfunction

	function automatic logic [MAC_W-1:0] rand_mac();
		logic [63:0] w;
		w = {$urandom, $urandom};
		return w[MAC_W-1:0];
	endfunction

	task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endtask

	// result checker: done is a one-cycle strobe with no back-pressure
	always @(posedge clk) begin
		arp_result_t want;
		if (arst_n && done === 1'b1) begin
			if (awaited_outcomes.size() == 0) begin
				mismatches++;
				$display("%0t: result with no request pending, expected none, actual status %0d",
					$time, status);
			end else begin
				want = awaited_outcomes.pop_front();
				check_field("status", 64'(want.status), 64'(status));
				check_field("hit", 64'(want.hit), 64'(hit));
				check_field("next_hop_ip", 64'(want.hop), 64'(next_hop_ip));
				check_field("mac_out", 64'(want.mac), 64'(mac_out));
			end
		end
	end

	// one register write, only while idle
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		case (idx)
			REG_HOST_IP:     cur_host = data;
			REG_SUBNET_MASK: cur_mask = data;
			REG_GATEWAY_IP:  cur_gateway = data;
			default: ;
		endcase
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_config(input logic [IP_W-1:0] host, input logic [IP_W-1:0] mask,
			input logic [IP_W-1:0] gw);
		write_reg(REG_HOST_IP, host);
		write_reg(REG_SUBNET_MASK, mask);
		write_reg(REG_GATEWAY_IP, gw);
	endtask

	// issue one request; start stays high across back-to-back requests
	task automatic send_request(input logic act, input logic [IP_W-1:0] ip,
			input logic [MAC_W-1:0] mac);
		int gap;
		gap = pace_on ? $urandom_range(0, 9) : 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		action <= act;
		ip_addr <= ip;
		mac_addr <= mac;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		awaited_outcomes.push_back(cache_outcome(act, ip, mac));
	endtask

	// hold off until every pending result has come back
	task automatic wait_idle();
		start <= 1'b0;
		@(posedge clk);
		while (awaited_outcomes.size() != 0)
			@(posedge clk);
	endtask

	// empty table, reset config: zero mask keeps everything on-subnet
	task automatic test_empty_table();
		send_request(ACT_RESOLVE, $urandom, rand_mac());
	endtask

	// all registers at their extremes, plus a write to the unused index
	task automatic test_config_regs();
		wait_idle();
		set_config('1, '1, '1);
		write_reg(REG_UNUSED, '1);
		send_request(ACT_RESOLVE, '0, '1);
		wait_idle();
		set_config('0, '0, '0);
		write_reg(REG_UNUSED, '0);
		send_request(ACT_RESOLVE, '1, '0);
	endtask

	// insert, update, and hits on the extreme addresses
	task automatic test_learn_update();
		send_request(ACT_LEARN, ip_pool[0], '1);
		send_request(ACT_LEARN, ip_pool[1], '0);
		send_request(ACT_LEARN, ip_pool[0], rand_mac());
		send_request(ACT_RESOLVE, ip_pool[0], '0);
		send_request(ACT_RESOLVE, ip_pool[1], '1);
	endtask

	// gateway selection for off-subnet, direct lookup on-subnet
	task automatic test_next_hop();
		logic [IP_W-1:0] remote;
		remote = ip_pool[2] ^ 32'h8000_0000;
		wait_idle();
		set_config(ip_pool[2], 32'hFFFF_FF00, ip_pool[3]);
		send_request(ACT_RESOLVE, remote, rand_mac());
		send_request(ACT_LEARN, ip_pool[3], rand_mac());
		send_request(ACT_RESOLVE, remote, rand_mac());
		send_request(ACT_LEARN, ip_pool[2], rand_mac());
		send_request(ACT_RESOLVE, (ip_pool[2] & 32'hFFFF_FF00) | 32'hA5, rand_mac());
		send_request(ACT_RESOLVE, ip_pool[2], rand_mac());
	endtask

	// fill the rest of the table, then a new address is dropped and a known one is updated
	task automatic test_full_table();
		for (int i = 4; i < POOL_SIZE; i++)
			send_request(ACT_LEARN, ip_pool[i], rand_mac());
		send_request(ACT_LEARN, rand_ip_outside_pool(), rand_mac());
		send_request(ACT_LEARN, ip_pool[5], rand_mac());
	endtask

	// random traffic over several register settings
	task automatic test_random_traffic();
		logic [IP_W-1:0] host;
		logic [IP_W-1:0] mask;
		logic [IP_W-1:0] gw;
		logic [IP_W-1:0] pick;
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			wait_idle();
			host = $urandom_range(0, 1) ? ip_pool[$urandom_range(0, POOL_SIZE - 1)] : $urandom;
			case (ph)
				0: mask = '0;
				1: mask = '1;
				default: mask = $urandom_range(0, 1) ? ('1 << $urandom_range(1, 31)) : $urandom;
			endcase
			case ($urandom_range(0, 3))
				0: gw = ip_pool[$urandom_range(0, POOL_SIZE - 1)];
				1: gw = $urandom;
				2: gw = '0;
				default: gw = '1;
			endcase
			set_config(host, mask, gw);
			if (ph == 0)
				write_reg(REG_UNUSED, $urandom);
			for (int n = 0; n < PHASE_REQUESTS; n++) begin
				if (n % 40 == 0)
					pace_on = 1'($urandom_range(0, 1));
				pick = ip_pool[$urandom_range(0, POOL_SIZE - 1)];
				case ($urandom_range(0, 9))
					0, 1, 2: send_request(ACT_LEARN, pick, rand_mac());
					3:       send_request(ACT_LEARN, $urandom, rand_mac());
					4, 5, 6: send_request(ACT_RESOLVE, pick, rand_mac());
					7: send_request(ACT_RESOLVE,
						(cur_host & cur_mask) | ($urandom & ~cur_mask), rand_mac());
					8:       send_request(ACT_RESOLVE, $urandom, rand_mac());
					default: send_request(ACT_RESOLVE, cur_gateway, rand_mac());
				endcase
			end
		end
	endtask

	initial begin
		// pool: both extremes plus distinct random addresses
		ip_pool[0] = '0;
		ip_pool[1] = '1;
		for (int i = 2; i < POOL_SIZE; i++) begin
			do
				ip_pool[i] = $urandom;
			while (in_pool(ip_pool[i], i));
		end
		for (int i = 0; i < N_ENTRIES; i++) begin
			tbl_valid[i] = 1'b0;
			tbl_ip[i] = '0;
			tbl_mac[i] = '0;
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_table();
		test_config_regs();
		test_learn_update();
		test_next_hop();
		test_full_table();
		test_random_traffic();

		wait_idle();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+design
design/arpc_pkg.sv
design/arpc_cell.sv
design/arp_cache_with_next_hop_top.sv
verif/testbench.sv
